>>> hdl/keyed_counter_table_macros.svh
// assertion macros for the keyed counter table rtl
`ifndef KEYED_COUNTER_TABLE_MACROS_SVH
`define KEYED_COUNTER_TABLE_MACROS_SVH

// same-cycle implication, checked on every rising clk outside reset
`define KCT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on every rising clk outside reset
`define KCT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/kct_pkg.sv
// types, constants and helpers for the keyed counter table
`default_nettype none

package kct_pkg;

	// table geometry and field widths
	localparam int KCT_ENTRIES = 64;
	localparam int KEY_W = 32;
	localparam int COUNT_W = 32;
	localparam int ENT_FIELD_W = 7;
	localparam logic [ENT_FIELD_W-1:0] ENT_FIELD_MAX = '1;

	// operation codes
	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_INCREMENT = 2'd2;

	// sequencer states
	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} kct_state_t;

	// input word
	typedef struct packed {
		logic [1:0] kind;
		logic [KEY_W-1:0] key;
	} kct_in_t;

	// result word
	typedef struct packed {
		logic found;
		logic status;
		logic [COUNT_W-1:0] entry_count;
		logic [COUNT_W-1:0] total_count;
		logic [ENT_FIELD_W-1:0] total_entries;
	} kct_out_t;

	// command broadcast to every cell during the execute cycle
	typedef struct packed {
		logic exec;
		logic [1:0] kind;
		logic [KEY_W-1:0] query;
		logic found;
		logic [KEY_W-1:0] tail_key;
		logic [COUNT_W-1:0] tail_hits;
	} kct_cmd_t;

	// what one cell shows to the rest of the table
	typedef struct packed {
		logic valid;
		logic match;
		logic tail;
		logic [KEY_W-1:0] key;
		logic [COUNT_W-1:0] hits;
	} kct_slot_t;

	// byte order reversal of a key
	function automatic logic [KEY_W-1:0] byte_swap(input logic [KEY_W-1:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

endpackage

`default_nettype wire

>>> hdl/kct_cell.sv
// one table slot: valid bit, key and saturating hit counter
`default_nettype none

module kct_cell
	import kct_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire kct_cmd_t  cmd,
	input  wire logic      prev_valid,
	input  wire logic      next_valid,
	output      kct_slot_t slot
);

	logic valid_q;
	logic [KEY_W-1:0] key_q;
	logic [COUNT_W-1:0] hits_q;
	logic match;
	logic tail;
	logic append;

	// compare and position within the packed run of live slots
	assign match = valid_q && (key_q == cmd.query);
	assign tail = valid_q && !next_valid;
	assign append = !valid_q && prev_valid;

	assign slot.valid = valid_q;
	assign slot.match = match;
	assign slot.tail = tail;
	assign slot.key = key_q;
	assign slot.hits = hits_q;

	// valid bit: set on append, cleared in the last live slot on a found delete
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.exec) begin
			case (cmd.kind)
				OP_ADD: begin
					if (!cmd.found && append) begin
						valid_q <= 1'b1;
					end
				end
				OP_DELETE: begin
					if (cmd.found && tail) begin
						valid_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// key and counter payload
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			case (cmd.kind)
				OP_ADD: begin
					if (!cmd.found && append) begin
						key_q <= cmd.query;
						hits_q <= '0;
					end
				end
				OP_DELETE: begin
					if (cmd.found && match && !tail) begin
						key_q <= cmd.tail_key;
						hits_q <= cmd.tail_hits;
					end
				end
				OP_INCREMENT: begin
					if (match && (hits_q != '1)) begin
						hits_q <= hits_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> hdl/keyed_counter_table.sv
// keyed counter table top level: command sequencer, cell row and totals
//
//   channel   ports                  handshake
//   command   start, busy, op        taken when start is high and busy is low
//   result    done, result           done high for one cycle, never stalled
//
// Each word passes the accept edge, then the execute state, in which
// every cell compares its key in parallel and the table updates.
// A new word can be taken in the cycle in which the previous result is shown.
// Live entries stay packed at the low end of the row, so an add appends after
// the last live cell and a delete moves the last live entry into the hole.
// Reset clears all valid bits, the total and the entry count at once.
`default_nettype none
`include "keyed_counter_table_macros.svh"

module keyed_counter_table
	import kct_pkg::*;
#(
	parameter int ENTRIES = KCT_ENTRIES
)
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	output      logic    busy,
	input  wire kct_in_t op,
	output      logic    done,
	output      kct_out_t result
);

	localparam int LIVE_W = $clog2(ENTRIES + 1);

	kct_state_t state_q;
	kct_state_t state_d;
	logic accept;
	logic exec;

	logic [1:0] kind_q;
	logic [KEY_W-1:0] query_q;

	kct_cmd_t cmd;
	kct_slot_t slot [ENTRIES];
	logic [ENTRIES-1:0] valid_vec;
	logic [ENTRIES-1:0] match_vec;
	logic found;
	logic full;
	logic [COUNT_W-1:0] sel_hits;
	logic [KEY_W-1:0] tail_key;
	logic [COUNT_W-1:0] tail_hits;

	logic [COUNT_W-1:0] total_q;
	logic [COUNT_W-1:0] total_d;
	logic [LIVE_W-1:0] live_q;
	logic [LIVE_W-1:0] live_d;
	logic [31:0] live_ext;
	logic r_found;
	logic r_status;
	logic [COUNT_W-1:0] r_ecount;
	kct_out_t res_q;
	logic done_q;

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		busy = 1'b0;
		exec = 1'b0;
		case (state_q)
			ST_IDLE: begin
			end
			ST_EXEC: begin
				busy = 1'b1;
				exec = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// command word capture, increment queries are swapped once here
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= op.kind;
			query_q <= (op.kind == OP_INCREMENT) ? byte_swap(op.key) : op.key;
		end
	end

	// row of cells, each sees the valid bits of its two neighbors
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		logic prev_valid;
		logic next_valid;
		if (i == 0) begin : g_first
			assign prev_valid = 1'b1;
		end else begin : g_prev
			assign prev_valid = slot[i-1].valid;
		end
		if (i == ENTRIES - 1) begin : g_last
			assign next_valid = 1'b0;
		end else begin : g_next
			assign next_valid = slot[i+1].valid;
		end
		kct_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.prev_valid (prev_valid),
			.next_valid (next_valid),
			.slot       (slot[i])
		);
	end

	// collect match, matched counter and last live entry from the row
	always_comb begin
		valid_vec = '0;
		match_vec = '0;
		sel_hits = '0;
		tail_key = '0;
		tail_hits = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			valid_vec[i] = slot[i].valid;
			match_vec[i] = slot[i].match;
			sel_hits = sel_hits | (slot[i].match ? slot[i].hits : '0);
			tail_key = tail_key | (slot[i].tail ? slot[i].key : '0);
			tail_hits = tail_hits | (slot[i].tail ? slot[i].hits : '0);
		end
	end

	assign found = |match_vec;
	assign full = valid_vec[ENTRIES-1];

	assign cmd.exec = exec;
	assign cmd.kind = kind_q;
	assign cmd.query = query_q;
	assign cmd.found = found;
	assign cmd.tail_key = tail_key;
	assign cmd.tail_hits = tail_hits;

	// result and running totals for the current word
	always_comb begin
		r_found = 1'b0;
		r_status = 1'b0;
		r_ecount = '0;
		total_d = total_q;
		live_d = live_q;
		case (kind_q)
			OP_ADD: begin
				if (found) begin
					r_found = 1'b1;
					r_ecount = sel_hits;
				end else if (full) begin
					r_status = 1'b1;
				end else begin
					live_d = live_q + 1'b1;
				end
			end
			OP_DELETE: begin
				if (found) begin
					r_found = 1'b1;
					r_ecount = sel_hits;
					total_d = (total_q >= sel_hits) ? (total_q - sel_hits) : '0;
					live_d = live_q - 1'b1;
				end
			end
			OP_INCREMENT: begin
				if (found) begin
					r_found = 1'b1;
					r_ecount = (sel_hits == '1) ? sel_hits : (sel_hits + 1'b1);
					total_d = (total_q == '1) ? total_q : (total_q + 1'b1);
				end
			end
			default: begin
			end
		endcase
	end

	assign live_ext = 32'(live_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			live_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= exec;
			if (exec) begin
				total_q <= total_d;
				live_q <= live_d;
			end
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (exec) begin
			res_q.found <= r_found;
			res_q.status <= r_status;
			res_q.entry_count <= r_ecount;
			res_q.total_count <= total_d;
			res_q.total_entries <= (live_ext > 32'(ENT_FIELD_MAX)) ? ENT_FIELD_MAX
				: live_ext[ENT_FIELD_W-1:0];
		end
	end

	assign done = done_q;
	assign result = res_q;

	// checks
	`KCT_ASSERT_NEXT(a_exec_gives_word, exec, done, "execute cycle gave no result word")
	`KCT_ASSERT_NOW(a_match_unique, 1'b1, $onehot0(match_vec), "more than one slot matches")
	`KCT_ASSERT_NOW(a_live_count, 1'b1, ($countones(valid_vec) == int'(live_q)), "live count off")
	`KCT_ASSERT_NOW(a_packed_row, 1'b1, (({1'b0, valid_vec} & ~{valid_vec, 1'b1}) == '0), "hole")
	`KCT_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted word did not raise busy")

endmodule

`default_nettype wire
